// ===== hdl/ept_pkg.sv =====
`default_nettype none
package ept_pkg;

  localparam int ANGLE_IN_W   = 12;
  localparam int ANGLE_BITS   = 12;
  localparam int TURN_W       = 32;
  localparam int TIME_W       = 32;
  localparam int MIN_W        = 16;
  localparam int KEEP_W       = 11;
  localparam int POS_W        = 44;
  localparam int VEL_W        = 29;
  localparam int FILT_W       = 33;
  localparam int FRAC_BITS    = 4;
  localparam int FILT_SHIFT   = 10;
  localparam int KEEP_MAX     = 1 << FILT_SHIFT;
  localparam int ACC_W        = FILT_W + KEEP_W + 1;

  localparam int TURN_COUNTS  = 1 << ANGLE_BITS;
  localparam int HALF_TURN    = 1 << (ANGLE_BITS - 1);
  localparam int TURN_JUMP    = (TURN_COUNTS * 4) / 5;
  localparam int DIFF_BITS    = ANGLE_BITS + 1;
  localparam int MAG_BITS     = ANGLE_BITS;
  localparam int US_PER_S     = 1000000;
  localparam int US_BITS      = 20;
  localparam int NUM_BITS     = MAG_BITS + US_BITS;
  localparam int DIV_CNT_BITS = $clog2(NUM_BITS);
  localparam int VEL_LIMIT    = 204800000;
  localparam int POS_WIDE_W   = TURN_W + ANGLE_BITS;

  localparam logic signed [DIFF_BITS-1:0] JUMP_S  = DIFF_BITS'(TURN_JUMP);
  localparam logic signed [DIFF_BITS-1:0] HALF_S  = DIFF_BITS'(HALF_TURN);
  localparam logic signed [DIFF_BITS-1:0] TURN_S  = DIFF_BITS'(TURN_COUNTS);
  localparam logic signed [VEL_W-1:0]     VEL_MAX = VEL_W'(VEL_LIMIT);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP      = 2'd2;

  localparam logic [MIN_W-1:0]  MIN_INT_RST = 16'd10;
  localparam logic [KEEP_W-1:0] KEEP_RST    = 11'd922;

  typedef enum logic [1:0] {
    VS_FIRST = 2'd0,
    VS_SHORT = 2'd1,
    VS_OK    = 2'd2
  } vstat_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_VEL,
    S_FILT1,
    S_FILT2,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic div_step;
    logic vel_fix;
    logic filt_mul;
    logic filt_acc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic short_iv;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/ept_ctrl.sv =====
`default_nettype none
module ept_ctrl
  import ept_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (sts_i.first) state_d = S_OUT;
        else if (sts_i.short_iv) state_d = S_FILT1;
        else state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_last) state_d = S_VEL;
      end
      S_VEL:   state_d = S_FILT1;
      S_FILT1: state_d = S_FILT2;
      S_FILT2: state_d = S_OUT;
      S_OUT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_in  = in_valid_i;
      end
      S_EVAL:  cmd_o.eval     = 1'b1;
      S_DIV:   cmd_o.div_step = 1'b1;
      S_VEL:   cmd_o.vel_fix  = 1'b1;
      S_FILT1: cmd_o.filt_mul = 1'b1;
      S_FILT2: cmd_o.filt_acc = 1'b1;
      S_OUT:   cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  a_accept_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_EVAL)
    else $error("accepted word did not start evaluation");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded over a pending word");

  a_first_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL && sts_i.first |=> state_q == S_OUT)
    else $error("first sample did not go straight to output");

endmodule
`default_nettype wire

// ===== hdl/ept_datapath.sv =====
`default_nettype none
module ept_datapath
  import ept_pkg::*;
(
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  [ANGLE_IN_W-1:0]        angle_raw_i,
  input  wire  [TIME_W-1:0]            timestamp_us_i,
  input  wire                          cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire  [CFG_DATA_W-1:0]        cfg_data_i,
  input  wire cmd_t                    cmd_i,
  output sts_t                         sts_o,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic signed [POS_W-1:0]      position_counts_o,
  output logic signed [VEL_W-1:0]      velocity_cps_o,
  output logic signed [FILT_W-1:0]     speed_filtered_o,
  output logic [1:0]                   velocity_status_o
);

  // configuration
  logic              dir_neg_q;
  logic [MIN_W-1:0]  min_int_q;
  logic [KEEP_W-1:0] keep_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_neg_q <= 1'b0;
      min_int_q <= MIN_INT_RST;
      keep_w_q  <= KEEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIRECTION: dir_neg_q <= cfg_data_i[0];
        CFG_MIN_INT:   min_int_q <= cfg_data_i[MIN_W-1:0];
        CFG_KEEP:      keep_w_q  <= cfg_data_i[KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // tracker state
  logic                     started_q;
  logic [TURN_W-1:0]        turn_count_q, turn_next;
  logic [ANGLE_BITS-1:0]    turn_last_q;
  logic [ANGLE_BITS-1:0]    vel_last_angle_q;
  logic [TIME_W-1:0]        vel_last_time_q;
  logic signed [FILT_W-1:0] filt_q;

  // work registers
  logic [ANGLE_BITS-1:0]    angle_q;
  logic [TIME_W-1:0]        time_q;
  logic [POS_W-1:0]         pos_q;
  logic [1:0]               vstat_q;
  logic                     neg_q;
  logic [NUM_BITS-1:0]      dividend_q;
  logic [TIME_W-1:0]        divisor_q;
  logic [TIME_W:0]          rem_q;
  logic [DIV_CNT_BITS-1:0]  cnt_q;
  logic signed [VEL_W-1:0]  vel_q;
  logic signed [ACC_W-1:0]  p1_q;

  // output stage
  logic                     out_valid_q;
  logic [POS_W-1:0]         out_pos_q;
  logic signed [VEL_W-1:0]  out_vel_q;
  logic signed [FILT_W-1:0] out_filt_q;
  logic [1:0]               out_stat_q;

  logic signed [DIFF_BITS-1:0] d_turn, dv_raw, dv;
  logic [POS_WIDE_W-1:0]       pos_wide;
  logic [TIME_W-1:0]           dt;
  logic                        short_iv;
  logic                        dv_neg;
  logic [DIFF_BITS-1:0]        dv_abs;
  logic [NUM_BITS-1:0]         num;
  logic [TIME_W:0]             rem_sh;
  logic                        ge;
  logic [VEL_W-2:0]            mag_sat;
  logic signed [VEL_W-1:0]     mag_s;
  logic [KEEP_W-1:0]           keep, wnew;
  logic signed [FILT_W-1:0]    v16;
  logic signed [ACC_W-1:0]     p1, p2, acc;

  always_comb begin
    d_turn = $signed({1'b0, angle_q}) - $signed({1'b0, turn_last_q});
    if (d_turn > JUMP_S) turn_next = turn_count_q - 1'b1;
    else if (d_turn < -JUMP_S) turn_next = turn_count_q + 1'b1;
    else turn_next = turn_count_q;
    pos_wide = {turn_next, angle_q};

    dt       = time_q - vel_last_time_q;
    short_iv = dt[TIME_W-1] || (dt == '0) || (dt < TIME_W'(min_int_q));

    dv_raw = $signed({1'b0, angle_q}) - $signed({1'b0, vel_last_angle_q});
    if (dv_raw > HALF_S) dv = dv_raw - TURN_S;
    else if (dv_raw < -HALF_S) dv = dv_raw + TURN_S;
    else dv = dv_raw;
    dv_neg = dv[DIFF_BITS-1];
    dv_abs = dv_neg ? DIFF_BITS'(-dv) : DIFF_BITS'(dv);
    num    = NUM_BITS'(dv_abs[MAG_BITS-1:0]) * NUM_BITS'(US_PER_S);

    rem_sh = {rem_q[TIME_W-1:0], dividend_q[NUM_BITS-1]};
    ge     = rem_sh >= {1'b0, divisor_q};

    mag_sat = (dividend_q > NUM_BITS'(VEL_LIMIT)) ? (VEL_W-1)'(VEL_LIMIT)
                                                 : (VEL_W-1)'(dividend_q);
    mag_s   = $signed({1'b0, mag_sat});

    keep = (keep_w_q > KEEP_W'(KEEP_MAX)) ? KEEP_W'(KEEP_MAX) : keep_w_q;
    wnew = KEEP_W'(KEEP_MAX) - keep;
    v16  = $signed({vel_q, {FRAC_BITS{1'b0}}});
    p1   = ACC_W'($signed({1'b0, keep})) * ACC_W'(filt_q);
    p2   = ACC_W'($signed({1'b0, wnew})) * ACC_W'(v16);
    acc  = p1_q + p2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q        <= 1'b0;
      turn_count_q     <= '0;
      turn_last_q      <= '0;
      vel_last_angle_q <= '0;
      vel_last_time_q  <= '0;
      filt_q           <= '0;
    end else if (cmd_i.eval) begin
      turn_last_q <= angle_q;
      if (!started_q) begin
        started_q        <= 1'b1;
        vel_last_angle_q <= angle_q;
        vel_last_time_q  <= time_q;
        filt_q           <= '0;
      end else begin
        turn_count_q <= turn_next;
        if (!short_iv) begin
          vel_last_angle_q <= angle_q;
          vel_last_time_q  <= time_q;
        end
      end
    end else if (cmd_i.filt_acc) begin
      filt_q <= acc[FILT_SHIFT +: FILT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      angle_q <= ANGLE_BITS'(angle_raw_i);
      time_q  <= timestamp_us_i;
    end
    if (cmd_i.eval) begin
      vel_q <= '0;
      if (!started_q) begin
        pos_q   <= '0;
        vstat_q <= VS_FIRST;
      end else begin
        pos_q <= POS_W'(pos_wide);
        if (short_iv) begin
          vstat_q <= VS_SHORT;
        end else begin
          vstat_q    <= VS_OK;
          neg_q      <= dv_neg;
          dividend_q <= num;
          divisor_q  <= dt;
          rem_q      <= '0;
          cnt_q      <= '0;
        end
      end
    end
    if (cmd_i.div_step) begin
      rem_q      <= ge ? rem_sh - {1'b0, divisor_q} : rem_sh;
      dividend_q <= {dividend_q[NUM_BITS-2:0], ge};
      cnt_q      <= cnt_q + 1'b1;
    end
    if (cmd_i.vel_fix) begin
      vel_q <= (neg_q ^ dir_neg_q) ? -mag_s : mag_s;
    end
    if (cmd_i.filt_mul) begin
      p1_q <= p1;
    end
    if (cmd_i.out_load) begin
      out_pos_q  <= pos_q;
      out_vel_q  <= vel_q;
      out_filt_q <= filt_q;
      out_stat_q <= vstat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.first    = !started_q;
  assign sts_o.short_iv = short_iv;
  assign sts_o.div_last = (cnt_q == DIV_CNT_BITS'(NUM_BITS - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign position_counts_o = out_pos_q;
  assign velocity_cps_o    = out_vel_q;
  assign speed_filtered_o  = out_filt_q;
  assign velocity_status_o = out_stat_q;

  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stat_q == VS_FIRST |-> out_pos_q == '0 && out_filt_q == '0)
    else $error("first sample word not zero");

  a_vel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stat_q != VS_OK |-> out_vel_q == '0)
    else $error("velocity nonzero without a measurement");

  a_vel_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_vel_q <= VEL_MAX && out_vel_q >= -VEL_MAX)
    else $error("velocity beyond saturation limit");

endmodule
`default_nettype wire

// ===== hdl/encoder_position_velocity_tracker.sv =====
// Encoder position and velocity tracker.
// Input channel (in_valid_i/in_ready_o): one word of angle_raw_i and
// timestamp_us_i. Output channel (out_valid_o/out_ready_i): one word of
// position, velocity, filtered speed and status per input word.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 direction, 1 minimum interval, 2 filter keep weight); write only idle.
// The 32-step restoring divider (one quotient bit per cycle) lies on the
// path of a measured velocity only; a first sample or a short interval
// bypasses it. A new word is taken in the cycle after the result is
// loaded; the block takes no new word before then.
// The result sits in an output register: the next word is accepted and
// processed while it waits; a stalled receiver holds the block only when
// the following result is ready to load.
// Reset: tracker state and filter clear, the next sample counts as the
// first, configuration returns to its defaults, no word is pending.
`default_nettype none
module encoder_position_velocity_tracker
  import ept_pkg::*;
(
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire  [ANGLE_IN_W-1:0]       angle_raw_i,
  input  wire  [TIME_W-1:0]           timestamp_us_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic signed [POS_W-1:0]     position_counts_o,
  output logic signed [VEL_W-1:0]     velocity_cps_o,
  output logic signed [FILT_W-1:0]    speed_filtered_o,
  output logic [1:0]                  velocity_status_o,
  input  wire                         cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire  [CFG_DATA_W-1:0]       cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  ept_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ept_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .angle_raw_i       (angle_raw_i),
    .timestamp_us_i    (timestamp_us_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .position_counts_o (position_counts_o),
    .velocity_cps_o    (velocity_cps_o),
    .speed_filtered_o  (speed_filtered_o),
    .velocity_status_o (velocity_status_o)
  );

endmodule
`default_nettype wire

// ===== tb/sv/encoder_position_velocity_tracker_tb.sv =====
module encoder_position_velocity_tracker_tb
  import ept_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_LEN    = 500;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 112;

  typedef struct {
    logic [ANGLE_IN_W-1:0] angle;
    logic [TIME_W-1:0]     stamp;
  } sample_t;

  typedef struct {
    logic [POS_W-1:0]  pos;
    logic [VEL_W-1:0]  vel;
    logic [FILT_W-1:0] spd;
    vstat_e            status;
  } track_out_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [ANGLE_IN_W-1:0]  angle_raw_i = '0;
  logic [TIME_W-1:0]      timestamp_us_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [POS_W-1:0]       position_counts_o;
  logic [VEL_W-1:0]       velocity_cps_o;
  logic [FILT_W-1:0]      speed_filtered_o;
  logic [1:0]             velocity_status_o;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  encoder_position_velocity_tracker uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .angle_raw_i       (angle_raw_i),
    .timestamp_us_i    (timestamp_us_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .position_counts_o (position_counts_o),
    .velocity_cps_o    (velocity_cps_o),
    .speed_filtered_o  (speed_filtered_o),
    .velocity_status_o (velocity_status_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // tracker model state and register copies
  bit                    trk_started = 1'b0;
  logic [TURN_W-1:0]     trk_turns = '0;
  logic [ANGLE_BITS-1:0] trk_last_angle = '0;
  logic [ANGLE_BITS-1:0] vel_last_angle = '0;
  logic [TIME_W-1:0]     vel_last_stamp = '0;
  longint                filt_speed = 0;
  bit                    dir_neg = 1'b0;
  logic [MIN_W-1:0]      min_iv = MIN_INT_RST;
  logic [KEEP_W-1:0]     keep_w = KEEP_RST;

  sample_t    pending_samples[$];
  track_out_t due_results[$];
  int         in_idle_pct = 0;
  int         out_idle_pct = 0;
  int         errors = 0;
  int         results_seen = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  int         quiet_cycles = 0;
  logic [ANGLE_IN_W-1:0] stim_angle = '0;
  logic [TIME_W-1:0]     stim_stamp = '0;

  function automatic track_out_t track_sample(logic [ANGLE_IN_W-1:0] raw,
                                              logic [TIME_W-1:0] stamp);
    logic [ANGLE_BITS-1:0] ang;
    logic [TIME_W-1:0]     dt;
    int                    d;
    int                    dv;
    longint                mag;
    longint                vel;
    longint                keep;
    longint                acc;
    track_out_t            r;
    ang = raw[ANGLE_BITS-1:0];
    vel = 0;
    r.pos = '0;
    if (!trk_started) begin
      trk_started = 1'b1;
      trk_last_angle = ang;
      vel_last_angle = ang;
      vel_last_stamp = stamp;
      filt_speed = 0;
      r.status = VS_FIRST;
    end else begin
      d = int'(ang) - int'(trk_last_angle);
      if (d > TURN_JUMP) begin
        trk_turns = trk_turns - 1;
      end else if (d < -TURN_JUMP) begin
        trk_turns = trk_turns + 1;
      end
      trk_last_angle = ang;
      r.pos = POS_W'({trk_turns, ang});
      dt = stamp - vel_last_stamp;
      if (dt[TIME_W-1] || dt == 0 || dt < min_iv) begin
        r.status = VS_SHORT;
      end else begin
        dv = int'(ang) - int'(vel_last_angle);
        if (dv > HALF_TURN) begin
          dv = dv - TURN_COUNTS;
        end else if (dv < -HALF_TURN) begin
          dv = dv + TURN_COUNTS;
        end
        mag = (longint'(dv < 0 ? -dv : dv) * US_PER_S) / longint'(dt);
        if (mag > VEL_LIMIT) mag = VEL_LIMIT;
        vel = (dv < 0) ? -mag : mag;
        if (dir_neg) vel = -vel;
        vel_last_angle = ang;
        vel_last_stamp = stamp;
        r.status = VS_OK;
      end
      keep = (keep_w > KEEP_MAX) ? KEEP_MAX : longint'(keep_w);
      acc = keep * filt_speed + (KEEP_MAX - keep) * (vel * (1 << FRAC_BITS));
      filt_speed = acc >>> FILT_SHIFT;
    end
    r.vel = vel[VEL_W-1:0];
    r.spd = filt_speed[FILT_W-1:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s at word %0d: got %0h, expected %0h", what, results_seen,
             got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_in
    sample_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        due_results.push_back(track_sample(angle_raw_i, timestamp_us_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          nxt = pending_samples.pop_front();
          in_valid_i <= 1'b1;
          angle_raw_i <= nxt.angle;
          timestamp_us_i <= nxt.stamp;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch_out
    track_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report("unexpected word", {20'd0, position_counts_o}, '0);
        end else begin
          want = due_results.pop_front();
          if (position_counts_o !== want.pos)
            report("position_counts", position_counts_o, want.pos);
          if (velocity_cps_o !== want.vel)
            report("velocity_cps", velocity_cps_o, want.vel);
          if (speed_filtered_o !== want.spd)
            report("speed_filtered", speed_filtered_o, want.spd);
          if (velocity_status_o !== want.status)
            report("velocity_status", velocity_status_o, want.status);
        end
      end
      // one long receiver stall so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  task automatic add_sample(logic [ANGLE_IN_W-1:0] a, logic [TIME_W-1:0] t);
    sample_t s;
    s.angle = a;
    s.stamp = t;
    pending_samples.push_back(s);
  endtask

  task automatic add_random_sample();
    int          sel;
    int          step;
    logic [TIME_W-1:0] dt;
    sel = $urandom_range(99);
    step = 0;
    dt = '0;
    if (sel < 55) begin
      step = int'($urandom_range(400)) - 200;
      dt = min_iv + $urandom_range(3000);
    end else if (sel < 70) begin
      step = int'($urandom_range(4096)) - 2048;
      dt = ((min_iv == 0) ? 1 : min_iv) + $urandom_range(40);
    end else if (sel < 82) begin
      step = int'($urandom_range(4095));
      dt = $urandom_range(200000);
    end else if (sel < 92) begin
      step = int'($urandom_range(60)) - 30;
      dt = $urandom_range(min_iv);
    end else begin
      stim_angle = ANGLE_IN_W'($urandom);
      stim_stamp = $urandom;
    end
    stim_angle = ANGLE_IN_W'(int'(stim_angle) + step);
    stim_stamp = stim_stamp + dt;
    add_sample(stim_angle, stim_stamp);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DIRECTION: dir_neg = val[0];
      CFG_MIN_INT:   min_iv = val[MIN_W-1:0];
      CFG_KEEP:      keep_w = val[KEEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid_i || due_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : run
    logic [CFG_DATA_W-1:0] min_val;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_idle_pct = 24;
    out_idle_pct = 24;
    add_sample(12'd0, 32'd1000);
    add_sample(12'd100, 32'd1100);
    add_sample(12'd4095, 32'd1200);
    add_sample(12'd0, 32'd1300);
    add_sample(12'd3276, 32'd1400);
    add_sample(12'd0, 32'd1500);
    add_sample(12'd3277, 32'd1600);
    add_sample(12'd0, 32'd1700);
    add_sample(12'd2048, 32'd1710);
    add_sample(12'd0, 32'd1720);
    add_sample(12'd2049, 32'd1730);
    add_sample(12'd2100, 32'd1739);
    add_sample(12'd2100, 32'd1730);
    add_sample(12'd2100, 32'd1000);
    add_sample(12'd2100, 32'h8000_06C2);
    add_sample(12'd2100, 32'h7FFF_FFFF);
    add_sample(12'd4095, 32'hFFFF_FFF0);
    add_sample(12'd4000, 32'h0000_0010);
    add_sample(12'd4095, 32'h0000_0100);
    add_sample(12'd0, 32'h0000_0200);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_DIRECTION, 16'd0);
          write_reg(CFG_MIN_INT, 16'd10);
          write_reg(CFG_KEEP, 16'd922);
        end
        1: begin
          write_reg(CFG_DIRECTION, 16'd1);
          write_reg(CFG_MIN_INT, 16'd0);
          write_reg(CFG_KEEP, 16'd0);
        end
        2: begin
          write_reg(CFG_DIRECTION, 16'd0);
          write_reg(CFG_MIN_INT, 16'hFFFF);
          write_reg(CFG_KEEP, 16'd1024);
        end
        3: begin
          write_reg(CFG_DIRECTION, 16'd1);
          write_reg(CFG_MIN_INT, 16'd1);
          write_reg(CFG_KEEP, 16'd2047);
        end
        default: begin
          min_val = $urandom_range(1) ? CFG_DATA_W'($urandom_range(200))
                                      : CFG_DATA_W'($urandom);
          write_reg(CFG_DIRECTION, CFG_DATA_W'($urandom_range(1)));
          write_reg(CFG_MIN_INT, min_val);
          write_reg(CFG_KEEP, CFG_DATA_W'($urandom_range(2047)));
        end
      endcase
      in_idle_pct = (ph == 0) ? 0 : 24;
      out_idle_pct = (ph == 0) ? 0 : 24;
      stim_angle = ANGLE_IN_W'($urandom);
      stim_stamp = $urandom;
      for (int i = 0; i < PHASE_WORDS; i++) add_random_sample();
      wait_idle();
    end

    repeat (40) @(posedge clk_i);
    if (errors == 0 && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
